@@ hdl/mhpq_pkg.sv @@
package mhpq_pkg;

	// Operation codes carried on the cmd field
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes
	localparam int STATUS_W = 2;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

endpackage

@@ hdl/mhpq_in_if.sv @@
interface mhpq_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ hdl/mhpq_out_if.sv @@
interface mhpq_out_if import mhpq_pkg::*; #(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 11
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] removed_value;
	logic signed [DATA_WIDTH-1:0] top_value;
	logic [COUNT_WIDTH-1:0]       entry_count;
	status_t                      status;

	modport source (output valid, output removed_value, output top_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input removed_value, input top_value,
		input entry_count, input status, output ready);
endinterface

@@ hdl/max_heap_priority_queue_top.sv @@
// Binary max-heap priority queue, one push or pop per input beat, one result beat each.
// A push sifts the new value up a level at a time; a pop refills the root from the last
// entry and sifts it down. One item at a time: the next beat is taken in the cycle after
// the result is loaded, and a result held off by the receiver stalls the input. One read
// port, one shared comparator.
// Reset clears the entry count and the sequencer; heap storage is not cleared.
module max_heap_priority_queue_top import mhpq_pkg::*; #(
	parameter int CAPACITY   = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mhpq_in_if.sink     in_ch,
	mhpq_out_if.source  out_ch
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = AW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP_RD  = 4'd1;
	localparam logic [3:0] S_UP_CMP = 4'd2;
	localparam logic [3:0] S_POP_LD = 4'd3;
	localparam logic [3:0] S_DN_RDL = 4'd4;
	localparam logic [3:0] S_DN_RDR = 4'd5;
	localparam logic [3:0] S_DN_SEL = 4'd6;
	localparam logic [3:0] S_DN_CMP = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	// Heap storage and its registered read data
	logic [DATA_WIDTH-1:0] heap_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [DATA_WIDTH-1:0] root_q;

	// Control state
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          out_valid_q;

	// Working registers
	logic [AW-1:0]         pos_q, pos_d;
	logic [KW-1:0]         kid_q, kid_d;
	logic [AW-1:0]         sel_idx_q, sel_idx_d;
	logic [DATA_WIDTH-1:0] cur_q, cur_d;
	logic [DATA_WIDTH-1:0] left_q, left_d;
	logic [DATA_WIDTH-1:0] sel_q, sel_d;
	logic [DATA_WIDTH-1:0] removed_q, removed_d;
	status_t               status_q, status_d;

	// Output register
	logic [DATA_WIDTH-1:0] out_removed_q;
	logic [DATA_WIDTH-1:0] out_top_q;
	logic [CW-1:0]         out_count_q;
	status_t               out_status_q;

	// Memory port controls
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;

	// Shared comparator
	logic [DATA_WIDTH-1:0] cmp_a;
	logic [DATA_WIDTH-1:0] cmp_b;
	logic                  cmp_lt;

	logic                  in_fire;
	logic                  out_load;
	logic [AW-1:0]         parent;
	logic [KW-1:0]         count_ext;
	logic [KW-1:0]         kid_p1;
	logic                  has_right;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
	assign parent    = (pos_q - AW'(1)) >> 1;
	assign count_ext = KW'(count_q);
	assign kid_p1    = kid_q + KW'(1);
	assign has_right = kid_p1 < count_ext;
	assign cmp_lt    = $signed(cmp_a) < $signed(cmp_b);

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.removed_value = out_removed_q;
	assign out_ch.top_value     = out_top_q;
	assign out_ch.entry_count   = out_count_q;
	assign out_ch.status        = out_status_q;

	// Steer the comparator operands
	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = rd_data_q;
				cmp_b = cur_q;
			end
			S_DN_SEL: begin
				cmp_a = left_q;
				cmp_b = rd_data_q;
			end
			S_DN_CMP: begin
				cmp_a = cur_q;
				cmp_b = sel_q;
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	// Sequence the sift walks
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		kid_d     = kid_q;
		sel_idx_d = sel_idx_q;
		cur_d     = cur_q;
		left_d    = left_q;
		sel_d     = sel_q;
		removed_d = removed_q;
		status_d  = status_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = cur_q;
		rd_en     = 1'b0;
		rd_addr   = parent;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					removed_d = '0;
					status_d  = ST_OK;
					if (in_ch.cmd == CMD_PUSH) begin
						if (count_q >= CAP_C) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							count_d = count_q + CW'(1);
							pos_d   = count_q[AW-1:0];
							cur_d   = in_ch.value;
							state_d = S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							removed_d = root_q;
							count_d   = count_q - CW'(1);
							rd_en     = 1'b1;
							rd_addr   = count_d[AW-1:0];
							pos_d     = '0;
							kid_d     = KW'(1);
							state_d   = S_POP_LD;
						end
					end
				end
			end
			S_UP_RD: begin
				// At the root: drop the value in place, else fetch the parent
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (cmp_lt) begin
					// Move the parent down into the hole
					wr_data = rd_data_q;
					pos_d   = parent;
					state_d = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP_LD: begin
				cur_d   = rd_data_q;
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (kid_q < count_ext) begin
					rd_en   = 1'b1;
					rd_addr = kid_q[AW-1:0];
					state_d = S_DN_RDR;
				end else begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DN_RDR: begin
				left_d  = rd_data_q;
				rd_en   = has_right;
				rd_addr = kid_p1[AW-1:0];
				state_d = S_DN_SEL;
			end
			S_DN_SEL: begin
				// Take the right child only when present and strictly greater
				if (has_right && cmp_lt) begin
					sel_d     = rd_data_q;
					sel_idx_d = kid_p1[AW-1:0];
				end else begin
					sel_d     = left_q;
					sel_idx_d = kid_q[AW-1:0];
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (cmp_lt) begin
					// Pull the larger child up into the hole
					wr_data = sel_q;
					pos_d   = sel_idx_q;
					kid_d   = {1'b0, sel_idx_q, 1'b1};
					state_d = S_DN_RDL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance working registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		kid_q     <= kid_d;
		sel_idx_q <= sel_idx_d;
		cur_q     <= cur_d;
		left_q    <= left_d;
		sel_q     <= sel_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (out_load) begin
			out_removed_q <= removed_q;
			out_top_q     <= (count_q != '0) ? root_q : '0;
			out_count_q   <= count_q;
			out_status_q  <= status_q;
		end
	end

	// Heap memory, one write and one registered read a cycle; shadow the root entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= heap_mem[rd_addr];
		end
		if (wr_en && (wr_addr == '0)) begin
			root_q <= wr_data;
		end
	end

endmodule
